// ----- hdl/ephm_pkg.sv -----
package ephm_pkg;

    localparam int EXPERTS_DEF    = 128;
    localparam int LAYERS_DEF     = 64;
    localparam int ID_SPACE       = 128;   // expert field is 7 bits
    localparam int CNT_W          = 48;
    localparam int OBS_W          = 16;
    localparam int UNION_W        = 8;
    localparam int RSP_FIFO_DEPTH = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DRAW   = 2'd1,
        OP_UBATCH = 2'd2,
        OP_TOTALS = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_OBS  = 2'd0,
        KIND_UB   = 2'd1,
        KIND_TOT1 = 2'd2,
        KIND_TOT2 = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] layer;
        logic [6:0] expert;
        logic       pin_value;
        logic       last_draw;
        logic       decode_phase;
    } t_req;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic [CNT_W-1:0] count_c;
        logic [CNT_W-1:0] count_d;
        logic             last;
    } t_rsp;

    // Results produced by one request, handed to the output queue.
    typedef struct packed {
        logic [1:0] n;
        t_rsp       r0;
        t_rsp       r1;
    } t_push;

    function automatic logic [CNT_W-1:0] sat48(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

// ----- hdl/expert_pin_hit_miss_accounting.sv -----
// A request is accepted and launches its pin-row read; the row is classified
//   in stage 1 and its results pass through the output queue to o_rsp.
// Throughput: one request per cycle unless o_req_stall; a totals read yields
//   two results; the 8-entry queue drains one per cycle unless i_rsp_stall.
// Reset: synchronous active-low i_rst_n clears layer-present flags, the
//   observation in progress, all bank totals and the result queue at once.
module expert_pin_hit_miss_accounting #(
    parameter int EXPERTS = ephm_pkg::EXPERTS_DEF,
    parameter int LAYERS  = ephm_pkg::LAYERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_stall,
    input  ephm_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_stall,
    output ephm_pkg::t_rsp o_rsp
);
    import ephm_pkg::*;

    localparam int AW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int QW = $clog2(RSP_FIFO_DEPTH);

    // Stage 0: accept request, launch pin-row read.
    // Stage 1: classify/update against the row, write the row back on loads.
    logic               accept;
    logic               r_s1_v;
    t_req               r_s1;
    logic [8:0]         in_lay9, s1_lay9;
    logic [AW-1:0]      in_addr, s1_addr;
    logic               wr_en;
    logic [EXPERTS-1:0] wr_data;
    logic [EXPERTS-1:0] row;
    logic               present;
    t_push              push;
    logic [QW:0]        q_cnt;

    assign accept  = i_req_valid && !o_req_stall;
    assign in_lay9 = {3'b000, i_req.layer};
    assign s1_lay9 = {3'b000, r_s1.layer};
    assign in_addr = in_lay9[AW-1:0];
    assign s1_addr = s1_lay9[AW-1:0];

    // Reserve room for up to two results in flight plus two for the new one.
    assign o_req_stall = (q_cnt + (r_s1_v ? (QW+1)'(2) : (QW+1)'(0)))
                         > (QW+1)'(RSP_FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= i_req;
        end
    end

    // Pin rows; a write in the same cycle as a read of that row is forwarded.
    ephm_pin_mem #(
        .EXPERTS (EXPERTS),
        .LAYERS  (LAYERS)
    ) u_pin_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (in_addr),
        .i_chk_addr (s1_addr),
        .i_wr_en    (wr_en),
        .i_wr_addr  (s1_addr),
        .i_wr_data  (wr_data),
        .o_present  (present),
        .o_row      (row)
    );

    ephm_acct #(
        .EXPERTS (EXPERTS),
        .LAYERS  (LAYERS)
    ) u_acct (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_v       (r_s1_v),
        .i_req     (r_s1),
        .i_present (present),
        .i_row     (row),
        .o_wr_en   (wr_en),
        .o_wr_data (wr_data),
        .o_push    (push)
    );

    ephm_out_fifo #(
        .DEPTH (RSP_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_rsp_stall),
        .o_valid (o_rsp_valid),
        .o_rsp   (o_rsp),
        .o_count (q_cnt)
    );

endmodule

// ----- hdl/ephm_pin_mem.sv -----
module ephm_pin_mem #(
    parameter int EXPERTS = ephm_pkg::EXPERTS_DEF,
    parameter int LAYERS  = ephm_pkg::LAYERS_DEF,
    localparam int AW     = (LAYERS > 1) ? $clog2(LAYERS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_chk_addr,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [EXPERTS-1:0] i_wr_data,
    output logic               o_present,
    output logic [EXPERTS-1:0] o_row
);
    import ephm_pkg::*;

    logic [EXPERTS-1:0] r_mem [LAYERS];
    logic [EXPERTS-1:0] r_rd;
    logic [LAYERS-1:0]  r_present;

    // write-first on a same-row collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= (i_wr_en && i_wr_addr == i_rd_addr) ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_wr_en) begin
            r_present[i_wr_addr] <= 1'b1;
        end
    end

    // rows never loaded read as all zero
    assign o_present = r_present[i_chk_addr];
    assign o_row     = o_present ? r_rd : '0;

endmodule

// ----- hdl/ephm_acct.sv -----
module ephm_acct #(
    parameter int EXPERTS = ephm_pkg::EXPERTS_DEF,
    parameter int LAYERS  = ephm_pkg::LAYERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_v,
    input  ephm_pkg::t_req     i_req,
    input  logic               i_present,
    input  logic [EXPERTS-1:0] i_row,
    output logic               o_wr_en,
    output logic [EXPERTS-1:0] o_wr_data,
    output ephm_pkg::t_push    o_push
);
    import ephm_pkg::*;

    localparam int EW = $clog2(EXPERTS);

    logic [ID_SPACE-1:0] r_seen_h, r_seen_m, n_seen_h, n_seen_m;
    logic [OBS_W-1:0]    r_hits, r_miss, n_hits, n_miss;
    logic [UNION_W-1:0]  r_hu, r_mu, n_hu, n_mu;

    logic [CNT_W-1:0]   r_draws [2];
    logic [CNT_W-1:0]   r_thits [2];
    logic [CNT_W-1:0]   r_tobs  [2];
    logic [CNT_W-1:0]   r_skip  [2];
    logic [CNT_W-1:0]   r_hsum  [2];
    logic [CNT_W-1:0]   r_msum  [2];
    logic [UNION_W-1:0] r_hpk   [2];
    logic [UNION_W-1:0] r_mpk   [2];
    logic [CNT_W-1:0]   r_ubh   [2];
    logic [CNT_W-1:0]   r_ubm   [2];

    logic [8:0]    lay9;
    logic          lay_ok, exp_ok, present, pinned, bank;
    logic [EW-1:0] eidx;
    logic [6:0]    id;
    logic          is_draw, do_fold, do_skip, do_ub;

    assign id      = i_req.expert;
    assign bank    = i_req.decode_phase;
    assign lay9    = {3'b000, i_req.layer};
    assign lay_ok  = lay9 < 9'(LAYERS);
    assign exp_ok  = {1'b0, id} < 8'(EXPERTS);
    assign eidx    = id[EW-1:0];
    assign present = lay_ok && i_present;
    assign pinned  = exp_ok && i_row[eidx];
    assign is_draw = i_v && (i_req.opcode == OP_DRAW);
    assign do_fold = is_draw && present && i_req.last_draw;
    assign do_skip = is_draw && !present && i_req.last_draw;
    assign do_ub   = i_v && (i_req.opcode == OP_UBATCH);

    // pin row rewrite
    always_comb begin
        o_wr_en   = i_v && (i_req.opcode == OP_LOAD) && lay_ok;
        o_wr_data = i_row;
        if (exp_ok) begin
            o_wr_data[eidx] = i_req.pin_value;
        end
    end

    // observation update for this draw
    always_comb begin
        n_seen_h = r_seen_h;
        n_seen_m = r_seen_m;
        n_hits   = r_hits;
        n_miss   = r_miss;
        n_hu     = r_hu;
        n_mu     = r_mu;
        if (is_draw && present) begin
            if (pinned) begin
                if (r_hits != '1) begin
                    n_hits = r_hits + 1'b1;
                end
                if (!r_seen_h[id]) begin
                    n_seen_h[id] = 1'b1;
                    n_hu         = r_hu + 1'b1;
                end
            end else begin
                if (r_miss != '1) begin
                    n_miss = r_miss + 1'b1;
                end
                if (!r_seen_m[id]) begin
                    n_seen_m[id] = 1'b1;
                    n_mu         = r_mu + 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_push    = '0;
        o_push.r0 = '0;
        o_push.r1 = '0;
        if (i_v) begin
            unique case (i_req.opcode)
                OP_LOAD: begin
                    o_push.n = 2'd0;
                end
                OP_DRAW: begin
                    o_push.n          = do_fold ? 2'd1 : 2'd0;
                    o_push.r0.kind    = KIND_OBS;
                    o_push.r0.count_a = CNT_W'(n_hits);
                    o_push.r0.count_b = CNT_W'(n_miss);
                    o_push.r0.count_c = CNT_W'(n_hu);
                    o_push.r0.count_d = CNT_W'(n_mu);
                    o_push.r0.last    = 1'b1;
                end
                OP_UBATCH: begin
                    o_push.n          = 2'd1;
                    o_push.r0.kind    = KIND_UB;
                    o_push.r0.count_a = r_ubh[bank];
                    o_push.r0.count_b = r_ubm[bank];
                    o_push.r0.last    = 1'b1;
                end
                OP_TOTALS: begin
                    o_push.n          = 2'd2;
                    o_push.r0.kind    = KIND_TOT1;
                    o_push.r0.count_a = r_draws[bank];
                    o_push.r0.count_b = r_thits[bank];
                    o_push.r0.count_c = r_tobs[bank];
                    o_push.r0.count_d = r_skip[bank];
                    o_push.r0.last    = 1'b0;
                    o_push.r1.kind    = KIND_TOT2;
                    o_push.r1.count_a = r_hsum[bank];
                    o_push.r1.count_b = r_msum[bank];
                    o_push.r1.count_c = CNT_W'(r_hpk[bank]);
                    o_push.r1.count_d = CNT_W'(r_mpk[bank]);
                    o_push.r1.last    = 1'b1;
                end
                default: begin
                    o_push.n = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_h <= '0;
            r_seen_m <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_hu     <= '0;
            r_mu     <= '0;
        end else if (do_fold || do_skip) begin
            r_seen_h <= '0;
            r_seen_m <= '0;
            r_hits   <= '0;
            r_miss   <= '0;
            r_hu     <= '0;
            r_mu     <= '0;
        end else begin
            r_seen_h <= n_seen_h;
            r_seen_m <= n_seen_m;
            r_hits   <= n_hits;
            r_miss   <= n_miss;
            r_hu     <= n_hu;
            r_mu     <= n_mu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_draws[k] <= '0;
                r_thits[k] <= '0;
                r_tobs[k]  <= '0;
                r_skip[k]  <= '0;
                r_hsum[k]  <= '0;
                r_msum[k]  <= '0;
                r_hpk[k]   <= '0;
                r_mpk[k]   <= '0;
                r_ubh[k]   <= '0;
                r_ubm[k]   <= '0;
            end
        end else begin
            if (do_fold) begin
                r_draws[bank] <= sat48(r_draws[bank], CNT_W'(n_hits) + CNT_W'(n_miss));
                r_thits[bank] <= sat48(r_thits[bank], CNT_W'(n_hits));
                r_tobs[bank]  <= sat48(r_tobs[bank], CNT_W'(1));
                r_hsum[bank]  <= sat48(r_hsum[bank], CNT_W'(n_hu));
                r_msum[bank]  <= sat48(r_msum[bank], CNT_W'(n_mu));
                r_ubh[bank]   <= sat48(r_ubh[bank], CNT_W'(n_hu));
                r_ubm[bank]   <= sat48(r_ubm[bank], CNT_W'(n_mu));
                if (n_hu > r_hpk[bank]) begin
                    r_hpk[bank] <= n_hu;
                end
                if (n_mu > r_mpk[bank]) begin
                    r_mpk[bank] <= n_mu;
                end
            end
            if (do_skip) begin
                r_skip[bank] <= sat48(r_skip[bank], CNT_W'(1));
            end
            if (do_ub) begin
                r_ubh[bank] <= '0;
                r_ubm[bank] <= '0;
            end
        end
    end

endmodule

// ----- hdl/ephm_out_fifo.sv -----
module ephm_out_fifo #(
    parameter int DEPTH = ephm_pkg::RSP_FIFO_DEPTH,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ephm_pkg::t_push i_push,
    input  logic            i_stall,
    output logic            o_valid,
    output ephm_pkg::t_rsp  o_rsp,
    output logic [PW:0]     o_count
);
    import ephm_pkg::*;

    t_rsp          r_q [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign o_rsp   = r_q[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_q[r_wp] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_q[r_wp + 1'b1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PW'(i_push.n);
            r_rp  <= r_rp + PW'(pop);
            r_cnt <= r_cnt + (PW+1)'(i_push.n) - (PW+1)'(pop);
        end
    end

endmodule

// ----- hdl/ephm_checker.sv -----
module ephm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_stall,
    input ephm_pkg::t_req i_req,
    input logic           o_rsp_valid,
    input logic           i_rsp_stall,
    input ephm_pkg::t_rsp o_rsp
);
    import ephm_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp_valid && !o_req_stall)
        else $error("block not empty after reset");

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_stall |=> i_req_valid && $stable(i_req))
        else $error("stalled request changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed");

    a_tot_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_stall && o_rsp.kind == KIND_TOT1
        |=> o_rsp_valid && o_rsp.kind == KIND_TOT2)
        else $error("totals part two does not follow part one");

    a_obs_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.kind == KIND_OBS
        |-> o_rsp.last && o_rsp.count_c <= o_rsp.count_a
            && o_rsp.count_d <= o_rsp.count_b)
        else $error("observation union exceeds count");

endmodule

bind expert_pin_hit_miss_accounting ephm_checker u_ephm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);
